>>> rtl/ria_pkg.sv
`timescale 1ns / 1ps
package ria_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int ID_W      = 6;
    localparam int CNT_W     = 7;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } ria_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_FREE  = 2'd3
    } ria_status_t;

    typedef struct packed {
        ria_op_t          opcode;
        logic [ID_W-1:0]  slot_id;
    } ria_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        ria_status_t      status;
    } ria_rsp_t;

    // Broadcast controls from the search sequencer to every cell
    typedef struct packed {
        logic step;   // advance the search token one cell
        logic flush;  // drop the search token everywhere
    } ria_cell_ctl_t;

endpackage

>>> rtl/ria_cell.sv
`timescale 1ns / 1ps
module ria_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ria_pkg::ria_cell_ctl_t ctl,
    input  logic                   load,
    input  logic                   rel,
    input  logic                   tok_in,
    output logic                   tok_out,
    output logic                   hit,
    output logic                   in_use
);
    import ria_pkg::*;

    logic in_use_reg;
    logic in_use_next;
    logic tok_reg;
    logic tok_next;

    // Token stops at a free cell; a busy cell hands it on
    assign hit     = tok_reg & ~in_use_reg;
    assign tok_out = tok_reg & in_use_reg;
    assign in_use  = in_use_reg;

    always_comb
    begin
        in_use_next = in_use_reg;
        if (rel)
        begin
            in_use_next = 1'b0;
        end
        else if (ctl.step && hit)
        begin
            in_use_next = 1'b1;
        end

        tok_next = tok_reg;
        if (ctl.flush)
        begin
            tok_next = 1'b0;
        end
        else if (load)
        begin
            tok_next = 1'b1;
        end
        else if (ctl.step)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            tok_reg    <= tok_next;
        end
    end

endmodule

>>> rtl/ria_row.sv
`timescale 1ns / 1ps
module ria_row (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ria_pkg::ria_cell_ctl_t              ctl,
    input  logic [ria_pkg::MAX_SLOTS-1:0]       load,
    input  logic [ria_pkg::MAX_SLOTS-1:0]       rel,
    input  logic [ria_pkg::ID_W-1:0]            last,
    output logic [ria_pkg::MAX_SLOTS-1:0]       in_use,
    output logic                                hit
);
    import ria_pkg::*;

    logic [MAX_SLOTS-1:0] tok_in;
    logic [MAX_SLOTS-1:0] tok_out;
    logic [MAX_SLOTS-1:0] hits;

    // Wrap the ring at the last slot of the table; cells beyond it never see the token
    always_comb
    begin
        for (int j = 0; j < MAX_SLOTS; j++)
        begin
            if (j == 0)
            begin
                tok_in[j] = tok_out[last];
            end
            else
            begin
                tok_in[j] = tok_out[j-1] & (ID_W'(j) <= last);
            end
        end
    end

    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_cell
        ria_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .load    (load[g]),
            .rel     (rel[g]),
            .tok_in  (tok_in[g]),
            .tok_out (tok_out[g]),
            .hit     (hits[g]),
            .in_use  (in_use[g])
        );
    end

    assign hit = |hits;

endmodule

>>> rtl/rotating_id_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Beat
// req       in         req_valid / req_ready     ria_req_t {opcode, slot_id}
// rsp       out        rsp_valid / rsp_ready     ria_rsp_t {granted_id, status}
// cfg       in         cfg_we (no wait)          cfg_data = slot_count
//
// Lookup, release, the unused opcode and allocate on an empty table finish at
// the accept edge; the response beat shows in the cycle after it.
// Allocate injects a token at the search start cell and walks the ring of slot
// cells one cell per cycle while the response register is free or draining,
// probing 1 .. slot count (max 64) slots before it grants or reports full.
// Reset clears the in-use bits, the search pointer and sets slot_count to 64.
// A held response beat freezes the search; a new request is taken only while
// no search runs and the response register is free or being drained.
module rotating_id_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ria_pkg::ria_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ria_pkg::ria_rsp_t           rsp,
    input  logic                        cfg_we,
    input  logic [ria_pkg::CNT_W-1:0]   cfg_data
);
    import ria_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  slot_count_reg;
    logic [ID_W-1:0]   search_start_reg, search_start_next;
    logic [ID_W-1:0]   probe_reg, probe_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic              rsp_valid_reg, rsp_valid_next;
    ria_rsp_t          rsp_reg, rsp_next;

    logic [CNT_W-1:0]     eff_n;
    logic [ID_W-1:0]      last;
    logic [ID_W-1:0]      start;
    logic [ID_W-1:0]      probe_wrap;
    logic                 out_free;
    logic                 accept;
    logic                 id_ok;
    logic                 id_busy;
    logic                 row_hit;
    logic                 search_step;
    logic [MAX_SLOTS-1:0] in_use;
    logic [MAX_SLOTS-1:0] load;
    logic [MAX_SLOTS-1:0] rel;
    ria_cell_ctl_t        ctl;

    // Cap the size register at the number of cells
    assign eff_n = (slot_count_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_reg;
    assign last  = ID_W'(eff_n - CNT_W'(1));
    assign start = ({1'b0, search_start_reg} >= eff_n) ? '0 : search_start_reg;

    assign probe_wrap = ({1'b0, probe_reg} + CNT_W'(1) >= eff_n) ? '0 : probe_reg + ID_W'(1);

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    assign id_ok   = {1'b0, req.slot_id} < eff_n;
    assign id_busy = in_use[req.slot_id];

    // Advance the token only while the response register can take a result
    assign search_step = (state_reg == S_SEARCH) && out_free;
    assign ctl = '{step:  search_step,
                   flush: search_step && !row_hit && (steps_reg + CNT_W'(1) == eff_n)};

    always_comb
    begin
        load = '0;
        rel  = '0;
        if (accept && req.opcode == OP_ALLOC && eff_n != '0)
        begin
            load[start] = 1'b1;
        end
        if (accept && req.opcode == OP_RELEASE && id_ok && id_busy)
        begin
            rel[req.slot_id] = 1'b1;
        end
    end

    ria_row u_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .load   (load),
        .rel    (rel),
        .last   (last),
        .in_use (in_use),
        .hit    (row_hit)
    );

    always_comb
    begin
        state_next        = state_reg;
        search_start_next = search_start_reg;
        probe_next        = probe_reg;
        steps_next        = steps_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.granted_id = req.slot_id;
                    rsp_next.status     = ST_OK;
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            if (eff_n == '0)
                            begin
                                rsp_next.granted_id = '0;
                                rsp_next.status     = ST_FULL;
                                rsp_valid_next      = 1'b1;
                            end
                            else
                            begin
                                probe_next = start;
                                steps_next = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_LOOKUP, OP_RELEASE:
                        begin
                            if (!id_ok)
                            begin
                                rsp_next.status = ST_RANGE;
                            end
                            else if (!id_busy)
                            begin
                                rsp_next.status = ST_FREE;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (ctl.step)
                begin
                    if (row_hit)
                    begin
                        // The cell under the token claims itself this edge
                        rsp_next.granted_id = probe_reg;
                        rsp_next.status     = ST_OK;
                        rsp_valid_next      = 1'b1;
                        search_start_next   = probe_wrap;
                        state_next          = S_IDLE;
                    end
                    else if (ctl.flush)
                    begin
                        rsp_next.granted_id = '0;
                        rsp_next.status     = ST_FULL;
                        rsp_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_wrap;
                        steps_next = steps_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_count_reg   <= CNT_W'(MAX_SLOTS);
            search_start_reg <= '0;
            probe_reg        <= '0;
            steps_reg        <= '0;
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            search_start_reg <= search_start_next;
            probe_reg        <= probe_next;
            steps_reg        <= steps_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_reg          <= rsp_next;
            if (cfg_we)
            begin
                slot_count_reg <= cfg_data;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> bench/ria_checker.sv
`timescale 1ns / 1ps
module ria_checker
    import ria_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  ria_req_t            req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  ria_rsp_t            rsp,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);

    logic [MAX_SLOTS-1:0]   busy_map;
    int                     next_probe;
    logic [CNT_W-1:0]       size_reg;
    ria_rsp_t               grants_due[$];
    int                     mismatches;

    // Apply one request to the shadow table and return the beat it must produce.
    function automatic ria_rsp_t resolve_request(input ria_req_t r);
        int         size;
        int         probe;
        int         k;
        bit         found;
        ria_rsp_t   o;
        size = (size_reg > MAX_SLOTS) ? MAX_SLOTS : int'(size_reg);
        o.granted_id = r.slot_id;
        o.status = ST_OK;
        case (r.opcode)
            OP_ALLOC:
            begin
                probe = (next_probe >= size) ? 0 : next_probe;
                found = 1'b0;
                o.granted_id = '0;
                o.status = ST_FULL;
                for (k = 0; k < size; k++)
                begin
                    if (!found)
                    begin
                        if (!busy_map[probe])
                            found = 1'b1;
                        else
                            probe = (probe + 1 >= size) ? 0 : probe + 1;
                    end
                end
                if (found)
                begin
                    busy_map[probe] = 1'b1;
                    o.granted_id = probe[ID_W-1:0];
                    o.status = ST_OK;
                    next_probe = (probe + 1 >= size) ? 0 : probe + 1;
                end
            end
            OP_LOOKUP, OP_RELEASE:
            begin
                if (int'(r.slot_id) >= size)
                    o.status = ST_RANGE;
                else if (!busy_map[r.slot_id])
                    o.status = ST_FREE;
                else if (r.opcode == OP_RELEASE)
                    busy_map[r.slot_id] = 1'b0;
            end
            default:
            begin
                o.status = ST_OK;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ria_rsp_t want;
        if (!rst_n)
        begin
            busy_map = '0;
            next_probe = 0;
            size_reg = 7'd64;
            grants_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // check the outgoing beat before taking a new request
            if (rsp_valid && rsp_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("response beat with nothing outstanding: granted_id %0d status %0d",
                           rsp.granted_id, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (rsp.granted_id !== want.granted_id)
                    begin
                        $error("granted_id: expected %0d, got %0d",
                               want.granted_id, rsp.granted_id);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                size_reg = cfg_data;
            if (req_valid && req_ready)
                grants_due.push_back(resolve_request(req));
            pending <= grants_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ria_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    ria_req_t           req;
    logic               rsp_valid;
    logic               rsp_ready;
    ria_rsp_t           rsp;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_data;
    int                 fail_count;
    int                 pending;

    // Quiet stretches: while a counter is nonzero that side never idles.
    int                 send_quiet;
    int                 recv_quiet;

    // Table sizes for the random phases: both ends, zero, and values past the cap.
    int                 phase_sizes[11] = '{64, 1, 9, 0, 127, 33, 2, 65, 13, 64, 5};

    rotating_id_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    ria_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: reports an error and stops the run if the test never finishes.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Draw the idle cycles ahead of one beat; now and then start a stretch with no idling.
    function automatic int idle_cycles(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Offer one request beat: idle first if drawn, then hold valid and payload until taken.
    // Called and returns at a falling edge.
    task automatic send_request(input ria_op_t op, input logic [ID_W-1:0] id);
        int gap;
        gap = idle_cycles(send_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req.opcode <= op;
        req.slot_id <= id;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drop valid, let every outstanding response drain, then write the size register.
    task automatic change_slot_count(input int value);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value[CNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Filling phases lean on allocate, draining phases on release, so the table
    // swings between full and empty and the rotating pointer wraps often.
    function automatic ria_op_t pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < (filling ? 55 : 20))
            return OP_ALLOC;
        if (r < (filling ? 70 : 35))
            return OP_LOOKUP;
        if (r < 95)
            return OP_RELEASE;
        return OP_NOP;
    endfunction

    // Mostly ids inside the table, the rest anywhere in the 6-bit field.
    function automatic logic [ID_W-1:0] pick_id(input int eff);
        if (eff > 0 && $urandom_range(0, 99) < 85)
            return ID_W'($urandom_range(0, eff - 1));
        return ID_W'($urandom_range(0, MAX_SLOTS - 1));
    endfunction

    // Response side: idle before each beat, and once hold ready low for a long
    // stretch so the block fills up and backs up the request channel.
    initial
    begin
        int w;
        int seen;
        rsp_ready = 1'b0;
        seen = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (seen == 600)
                w = 400;
            else
                w = idle_cycles(recv_quiet);
            if (w > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            seen++;
            @(negedge clk);
        end
    end

    initial
    begin
        int eff;
        bit filling;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        send_quiet = 0;
        recv_quiet = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a four-slot table, filled to the brim and then poked at.
        change_slot_count(4);
        repeat (4) send_request(OP_ALLOC, 6'd63);
        send_request(OP_ALLOC, 6'd0);          // full table
        send_request(OP_LOOKUP, 6'd0);
        send_request(OP_LOOKUP, 6'd63);        // out of range, top of the field
        send_request(OP_LOOKUP, 6'd4);         // first id past the size
        send_request(OP_RELEASE, 6'd2);
        send_request(OP_RELEASE, 6'd2);        // already free
        send_request(OP_LOOKUP, 6'd2);
        send_request(OP_ALLOC, 6'd0);          // refills the released hole
        send_request(OP_NOP, 6'd63);
        send_request(OP_NOP, 6'd0);
        send_request(OP_RELEASE, 6'd5);

        // Shrink below the search pointer: the search restarts at slot zero and
        // the in-use bits above the size stay hidden.
        change_slot_count(2);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_LOOKUP, 6'd3);
        send_request(OP_RELEASE, 6'd1);
        send_request(OP_ALLOC, 6'd0);

        // Empty table: everything is full or out of range.
        change_slot_count(0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_LOOKUP, 6'd0);
        send_request(OP_RELEASE, 6'd0);

        // Grow back: the hidden bit above the old size shows up again.
        change_slot_count(64);
        send_request(OP_LOOKUP, 6'd3);
        send_request(OP_RELEASE, 6'd3);
        send_request(OP_ALLOC, 6'd0);

        // Random phases, alternating fill and drain every 40 beats.
        for (int p = 0; p < 11; p++)
        begin
            change_slot_count(phase_sizes[p]);
            eff = (phase_sizes[p] > MAX_SLOTS) ? MAX_SLOTS : phase_sizes[p];
            for (int i = 0; i < 170; i++)
            begin
                filling = ((i / 40) % 2) == 0;
                send_request(pick_op(filling), pick_id(eff));
            end
        end

        // Drain, then allow for a full search before the verdict.
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/ria_pkg.sv
rtl/ria_cell.sv
rtl/ria_row.sv
rtl/rotating_id_allocator.sv
bench/ria_checker.sv
bench/tb_top.sv
